[design/xme_pkg.sv]
// Package for the x86 ModRM/SIB instruction encoder.
// Holds item types, form codes, the encoded-record type and sizing constants.
// No dependencies.
package xme_pkg;

	localparam int MAX_BYTES   = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int IDX_W       = $clog2(MAX_BYTES);
	localparam int CNT_W       = $clog2(MAX_BYTES + 1);

	localparam logic [3:0] SP_REG     = 4'h4;
	localparam logic [7:0] SIB_SP     = 8'h24;
	localparam logic [7:0] MOD_DIRECT = 8'h00;
	localparam logic [7:0] MOD_DISP32 = 8'h02 << 6;

	typedef enum logic [3:0] {
		FN_NONE = 4'd0,
		FN_UR   = 4'd1,
		FN_UM   = 4'd2,
		FN_UMO  = 4'd3,
		FN_BRR  = 4'd4,
		FN_BMR  = 4'd5,
		FN_BRM  = 4'd6,
		FN_BMRO = 4'd7,
		FN_BRMO = 4'd8,
		FN_BRI  = 4'd9
	} func_t;

	typedef struct packed {
		logic [3:0]         func;
		logic [7:0]         rex_byte;
		logic [7:0]         opcode_byte;
		logic [7:0]         sub_byte;
		logic [3:0]         dst_reg;
		logic [3:0]         src_reg;
		logic signed [31:0] displacement;
		logic signed [31:0] immediate;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
	} enc_rec_t;

	function automatic logic [7:0] modrm(input logic [7:0] mode, input logic [3:0] regf,
			input logic [3:0] base);
		modrm = mode | {2'b00, regf[2:0], 3'b000} | {5'b00000, base[2:0]};
	endfunction

endpackage

[design/xme_front.sv]
// Front end: accepts instruction requests and lays out their machine-code bytes.
// Registers one encoded record per cycle toward the queue while the queue is not full. Depends on xme_pkg.
module xme_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  xme_pkg::in_item_t  instr,
	output logic               q_push,
	input  logic               q_full,
	output xme_pkg::enc_rec_t  q_data
);
	import xme_pkg::*;

	logic       accept;
	logic       valid_s1;
	enc_rec_t   rec_s1;
	enc_rec_t   rec_d;

	logic       rex_en;
	logic [7:0] b0;
	logic       b1_en;
	logic [7:0] b1;
	logic       sib_en;
	logic       tail_en;
	logic [31:0] tail;
	logic       defined;

	always_comb begin
		rex_en  = 1'b0;
		b0      = instr.opcode_byte;
		b1_en   = 1'b0;
		b1      = 8'h00;
		sib_en  = 1'b0;
		tail_en = 1'b0;
		tail    = instr.displacement;
		defined = 1'b1;
		case (func_t'(instr.func))
			FN_NONE: begin
			end
			FN_UR: begin
				if (instr.sub_byte != 8'h00) begin
					b1_en = 1'b1;
					b1    = instr.sub_byte | {5'b00000, instr.dst_reg[2:0]};
				end else begin
					b0 = instr.opcode_byte | {5'b00000, instr.dst_reg[2:0]};
				end
			end
			FN_UM: begin
				b1_en  = 1'b1;
				b1     = modrm(MOD_DIRECT, instr.sub_byte[3:0], instr.dst_reg);
				sib_en = (instr.dst_reg == SP_REG);
			end
			FN_UMO: begin
				b1_en   = 1'b1;
				b1      = modrm(MOD_DISP32, 4'h0, instr.dst_reg);
				sib_en  = (instr.dst_reg == SP_REG);
				tail_en = 1'b1;
			end
			FN_BRR: begin
				b1_en = 1'b1;
				b1    = instr.sub_byte | modrm(MOD_DIRECT, instr.src_reg, instr.dst_reg);
			end
			FN_BMR: begin
				b1_en  = 1'b1;
				b1     = modrm(MOD_DIRECT, instr.src_reg, instr.dst_reg);
				sib_en = (instr.dst_reg == SP_REG);
			end
			FN_BRM: begin
				b1_en  = 1'b1;
				b1     = modrm(MOD_DIRECT, instr.dst_reg, instr.src_reg);
				sib_en = (instr.src_reg == SP_REG);
			end
			FN_BMRO: begin
				b1_en   = 1'b1;
				b1      = modrm(MOD_DISP32, instr.src_reg, instr.dst_reg);
				sib_en  = (instr.dst_reg == SP_REG);
				tail_en = 1'b1;
			end
			FN_BRMO: begin
				b1_en   = 1'b1;
				b1      = modrm(MOD_DISP32, instr.dst_reg, instr.src_reg);
				sib_en  = (instr.src_reg == SP_REG);
				tail_en = 1'b1;
			end
			FN_BRI: begin
				b0      = instr.opcode_byte | {5'b00000, instr.dst_reg[2:0]};
				tail_en = 1'b1;
				tail    = instr.immediate;
			end
			default: begin
				defined = 1'b0;
			end
		endcase
		if (func_t'(instr.func) != FN_BRI) begin
			rex_en = (instr.rex_byte != 8'h00);
		end
	end

	// pack the segments in emission order
	always_comb begin
		logic [CNT_W-1:0] n;
		n           = '0;
		rec_d.bytes = '0;
		if (rex_en) begin
			rec_d.bytes[n[IDX_W-1:0]] = instr.rex_byte;
			n = n + CNT_W'(1);
		end
		rec_d.bytes[n[IDX_W-1:0]] = b0;
		n = n + CNT_W'(1);
		if (b1_en) begin
			rec_d.bytes[n[IDX_W-1:0]] = b1;
			n = n + CNT_W'(1);
		end
		if (sib_en) begin
			rec_d.bytes[n[IDX_W-1:0]] = SIB_SP;
			n = n + CNT_W'(1);
		end
		if (tail_en) begin
			for (int k = 0; k < 4; k++) begin
				rec_d.bytes[IDX_W'(n + CNT_W'(k))] = tail[8*k +: 8];
			end
			n = n + CNT_W'(4);
		end
		rec_d.count = defined ? n : '0;
	end

	assign q_push = valid_s1 && !q_full;
	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_data = rec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (rec_d.count != '0);
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_s1 <= rec_d;
		end
	end

endmodule

[design/xme_queue.sv]
// Short record queue between front end and byte sequencer.
// Depends on xme_pkg for the record type.
module xme_queue #(
	parameter int DEPTH = xme_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  xme_pkg::enc_rec_t wdata,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output xme_pkg::enc_rec_t rdata
);
	import xme_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	enc_rec_t            mem [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [FILL_W-1:0]   fill_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (fill_q == FILL_W'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue read while empty");
	a_nonzero_rec: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (wdata.count != '0)) else $error("empty record queued");
`endif

endmodule

[design/xme_back.sv]
// Byte sequencer: takes encoded records from the queue and emits one beat per byte.
// Depends on xme_pkg.
module xme_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  xme_pkg::enc_rec_t  q_data,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output xme_pkg::out_item_t result
);
	import xme_pkg::*;

	enc_rec_t          cur_q;
	logic [IDX_W-1:0]  idx_q;
	logic              valid_q;
	logic              is_last;
	logic              take;

	assign is_last       = ({1'b0, idx_q} + CNT_W'(1) == cur_q.count);
	assign take          = pop && valid_q;
	assign q_pop         = !q_empty && (!valid_q || (take && is_last));
	assign empty         = !valid_q;
	assign result.out_byte = cur_q.bytes[idx_q];
	assign result.last     = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ({1'b0, idx_q} < cur_q.count)) else $error("byte index past count");
	a_hold_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !is_last) |=> (valid_q && idx_q == $past(idx_q) + IDX_W'(1)))
		else $error("instruction cut short");
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (idx_q == '0 && valid_q)) else $error("record not started at byte zero");
`endif

endmodule

[design/x86_modrm_instruction_encoder.sv]
// Top level of the x86 ModRM/SIB instruction encoder.
// Instantiates xme_front, xme_queue and xme_back; depends on xme_pkg.
//
//   channel   handshake        payload
//   request   push / full      instr  (xme_pkg::in_item_t)
//   bytes     empty / pop      result (xme_pkg::out_item_t)
//
// A request is encoded combinationally into a record of up to eight bytes,
// registered and queued, so requests are taken while earlier bytes drain;
// the sequencer emits one byte beat per cycle while pop is held. A record
// passes the front-end, queue and sequencer registers before its first beat.
// Undefined forms are dropped in the front end. Reset clears all valid state;
// a stall on the byte side fills the queue and then raises full.
module x86_modrm_instruction_encoder #(
	parameter int QUEUE_DEPTH = xme_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  xme_pkg::in_item_t  instr,
	output logic               empty,
	input  logic               pop,
	output xme_pkg::out_item_t result
);
	import xme_pkg::*;

	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_empty;
	enc_rec_t q_wdata;
	enc_rec_t q_rdata;

	xme_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.instr  (instr),
		.q_push (q_push),
		.q_full (q_full),
		.q_data (q_wdata)
	);

	xme_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	xme_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

[test/xme_byte_checker.sv]
// Byte-stream checker for the x86 ModRM/SIB instruction encoder testbench.
// Watches the request and byte channels, encodes each accepted request on its own
// and compares every byte beat in order; depends on xme_pkg.
`timescale 1ns / 100ps

module xme_byte_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  xme_pkg::in_item_t  instr,
	input  logic               empty,
	input  logic               pop,
	input  xme_pkg::out_item_t result,
	output int                 fail_count,
	output int                 pending,
	output int                 beats
);

	import xme_pkg::*;

	logic [7:0] enc_buf[$];
	out_item_t  expected_beats[$];

	function automatic void emit_prefix(input logic [7:0] rex, input logic [7:0] op);
		if (rex != 8'h00)
			enc_buf.push_back(rex);
		enc_buf.push_back(op);
	endfunction

	function automatic void emit_mem(input logic [7:0] mode, input logic [3:0] regf,
			input logic [3:0] base);
		if (base == SP_REG) begin
			enc_buf.push_back(mode | {2'b00, regf[2:0], 3'b100});
			enc_buf.push_back(SIB_SP);
		end else begin
			enc_buf.push_back(mode | {2'b00, regf[2:0], base[2:0]});
		end
	endfunction

	function automatic void emit_dword(input logic [31:0] v);
		enc_buf.push_back(v[7:0]);
		enc_buf.push_back(v[15:8]);
		enc_buf.push_back(v[23:16]);
		enc_buf.push_back(v[31:24]);
	endfunction

	function automatic void encode_request(input in_item_t rq);
		out_item_t beat;
		enc_buf.delete();
		case (rq.func)
			FN_NONE: begin
				emit_prefix(rq.rex_byte, rq.opcode_byte);
			end
			FN_UR: begin
				if (rq.rex_byte != 8'h00)
					enc_buf.push_back(rq.rex_byte);
				if (rq.sub_byte != 8'h00) begin
					enc_buf.push_back(rq.opcode_byte);
					enc_buf.push_back(rq.sub_byte | {5'b00000, rq.dst_reg[2:0]});
				end else begin
					enc_buf.push_back(rq.opcode_byte | {5'b00000, rq.dst_reg[2:0]});
				end
			end
			FN_UM: begin
				emit_prefix(rq.rex_byte, rq.opcode_byte);
				emit_mem(MOD_DIRECT, rq.sub_byte[3:0], rq.dst_reg);
			end
			FN_UMO: begin
				emit_prefix(rq.rex_byte, rq.opcode_byte);
				emit_mem(MOD_DISP32, 4'h0, rq.dst_reg);
				emit_dword(rq.displacement);
			end
			FN_BRR: begin
				emit_prefix(rq.rex_byte, rq.opcode_byte);
				enc_buf.push_back(rq.sub_byte | {2'b00, rq.src_reg[2:0], rq.dst_reg[2:0]});
			end
			FN_BMR: begin
				emit_prefix(rq.rex_byte, rq.opcode_byte);
				emit_mem(MOD_DIRECT, rq.src_reg, rq.dst_reg);
			end
			FN_BRM: begin
				emit_prefix(rq.rex_byte, rq.opcode_byte);
				emit_mem(MOD_DIRECT, rq.dst_reg, rq.src_reg);
			end
			FN_BMRO: begin
				emit_prefix(rq.rex_byte, rq.opcode_byte);
				emit_mem(MOD_DISP32, rq.src_reg, rq.dst_reg);
				emit_dword(rq.displacement);
			end
			FN_BRMO: begin
				emit_prefix(rq.rex_byte, rq.opcode_byte);
				emit_mem(MOD_DISP32, rq.dst_reg, rq.src_reg);
				emit_dword(rq.displacement);
			end
			FN_BRI: begin
				enc_buf.push_back(rq.opcode_byte | {5'b00000, rq.dst_reg[2:0]});
				emit_dword(rq.immediate);
			end
			default: begin
			end
		endcase
		foreach (enc_buf[i]) begin
			beat.out_byte = enc_buf[i];
			beat.last = (i == enc_buf.size() - 1);
			expected_beats.push_back(beat);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			expected_beats.delete();
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				beats++;
				if (expected_beats.size() == 0) begin
					fail_count++;
					$display("%0t unexpected beat: expected none, actual byte %02h last %0b",
						$time, result.out_byte, result.last);
				end else begin
					want = expected_beats.pop_front();
					if (result.out_byte !== want.out_byte) begin
						fail_count++;
						$display("%0t out_byte mismatch: expected %02h, actual %02h",
							$time, want.out_byte, result.out_byte);
					end
					if (result.last !== want.last) begin
						fail_count++;
						$display("%0t last mismatch on byte %02h: expected %0b, actual %0b",
							$time, want.out_byte, want.last, result.last);
					end
				end
			end
			if (push && !full)
				encode_request(instr);
			pending <= expected_beats.size();
		end
	end

endmodule

[test/tb_x86_modrm_instruction_encoder.sv]
// Testbench top for x86_modrm_instruction_encoder: directed and random requests
// with random idling on both sides and one long byte-side hold-off.
// Depends on xme_pkg, the encoder RTL and xme_byte_checker.
`timescale 1ns / 100ps

module tb_x86_modrm_instruction_encoder;

	import xme_pkg::*;

	localparam int          RANDOM_REQUESTS = 320;
	localparam int          MAX_WAIT        = 18;
	localparam int          HOLD_START      = 150;
	localparam int          HOLD_CYCLES     = 300;
	localparam int          DRAIN_CYCLES    = 16;
	localparam int          CYCLE_LIMIT     = 500000;
	localparam logic [3:0]  FN_UNDEF_LO     = 4'hA;
	localparam logic [3:0]  FN_UNDEF_HI     = 4'hF;

	logic       clk     = 1'b0;
	logic       arst_n  = 1'b0;
	logic       push    = 1'b0;
	logic       pop     = 1'b0;
	logic       hold_rx = 1'b0;
	logic       full;
	logic       empty;
	in_item_t   instr   = '0;
	out_item_t  result;

	int fail_count;
	int pending;
	int beats;
	int sent;
	int dropped;
	int full_stalls;
	int cycle_count;
	bit tx_steady;
	bit rx_steady;

	x86_modrm_instruction_encoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.instr  (instr),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	xme_byte_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.instr      (instr),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending),
		.beats      (beats)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic in_item_t make_request(input logic [3:0] fn, input logic [7:0] rex,
			input logic [7:0] op, input logic [7:0] sub, input logic [3:0] dst,
			input logic [3:0] src, input logic [31:0] disp, input logic [31:0] imm);
		in_item_t rq;
		rq.func         = fn;
		rq.rex_byte     = rex;
		rq.opcode_byte  = op;
		rq.sub_byte     = sub;
		rq.dst_reg      = dst;
		rq.src_reg      = src;
		rq.displacement = disp;
		rq.immediate    = imm;
		return rq;
	endfunction

	function automatic in_item_t random_request();
		in_item_t     rq;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		rq = raw[$bits(in_item_t)-1:0];
		if ($urandom_range(0, 11) != 0)
			rq.func = 4'($urandom_range(int'(FN_NONE), int'(FN_BRI)));
		else
			rq.func = 4'($urandom_range(int'(FN_UNDEF_LO), int'(FN_UNDEF_HI)));
		if ($urandom_range(0, 1) == 0)
			rq.rex_byte = 8'h00;
		if ($urandom_range(0, 3) == 0)
			rq.sub_byte = 8'h00;
		if ($urandom_range(0, 2) == 0)
			rq.dst_reg = {1'($urandom_range(0, 1)), SP_REG[2:0]};
		if ($urandom_range(0, 2) == 0)
			rq.src_reg = {1'($urandom_range(0, 1)), SP_REG[2:0]};
		return rq;
	endfunction

	task automatic send_request(input in_item_t rq);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		instr <= rq;
		@(posedge clk);
		while (full) @(posedge clk);
		if (rq.func > FN_BRI)
			dropped++;
		else
			sent++;
	endtask

	initial begin : stimulus
		in_item_t directed[$];
		int n;
		directed.push_back(make_request(FN_NONE, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 0, 0));
		directed.push_back(make_request(FN_NONE, 8'hFF, 8'hFF, 8'hFF, 4'hF, 4'hF,
			32'hFFFFFFFF, 32'hFFFFFFFF));
		directed.push_back(make_request(FN_UR, 8'h48, 8'hFF, 8'hD0, 4'h7, 4'h0, 0, 0));
		directed.push_back(make_request(FN_UR, 8'h00, 8'h50, 8'h00, 4'hF, 4'h0, 0, 0));
		directed.push_back(make_request(FN_UM, 8'h48, 8'hFF, 8'h02, 4'h4, 4'h0, 0, 0));
		directed.push_back(make_request(FN_UM, 8'h00, 8'hFF, 8'hFF, 4'hC, 4'h4, 0, 0));
		directed.push_back(make_request(FN_UMO, 8'h48, 8'hFF, 8'hFF, 4'h4, 4'h0,
			32'h80000000, 0));
		directed.push_back(make_request(FN_UMO, 8'h00, 8'h8F, 8'h00, 4'h5, 4'h0,
			32'h7FFFFFFF, 0));
		directed.push_back(make_request(FN_BRR, 8'h48, 8'h89, 8'hC0, 4'hF, 4'hF, 0, 0));
		directed.push_back(make_request(FN_BRR, 8'h00, 8'h01, 8'h00, 4'h0, 4'h4, 0, 0));
		directed.push_back(make_request(FN_BMR, 8'h4C, 8'h89, 8'h00, 4'h4, 4'hC, 0, 0));
		directed.push_back(make_request(FN_BMR, 8'h00, 8'h89, 8'hFF, 4'hC, 4'h4, 0, 0));
		directed.push_back(make_request(FN_BRM, 8'h48, 8'h8B, 8'h00, 4'h4, 4'h4, 0, 0));
		directed.push_back(make_request(FN_BRM, 8'h49, 8'h8B, 8'h00, 4'h9, 4'hC, 0, 0));
		directed.push_back(make_request(FN_BMRO, 8'h48, 8'h89, 8'h00, 4'h4, 4'h7,
			32'hFFFFFFFF, 0));
		directed.push_back(make_request(FN_BMRO, 8'hFF, 8'hFF, 8'hFF, 4'hD, 4'hF, 0, 0));
		directed.push_back(make_request(FN_BRMO, 8'h4C, 8'h8B, 8'h00, 4'h3, 4'h4,
			32'h12345678, 0));
		directed.push_back(make_request(FN_BRMO, 8'h00, 8'h8B, 8'h00, 4'hF, 4'hC,
			32'h80000000, 0));
		directed.push_back(make_request(FN_BRI, 8'h48, 8'hB8, 8'hFF, 4'hF, 4'h0, 0,
			32'h80000000));
		directed.push_back(make_request(FN_BRI, 8'h00, 8'hB8, 8'h00, 4'h4, 4'h0, 0,
			32'h7FFFFFFF));
		directed.push_back(make_request(FN_BRI, 8'h00, 8'hFF, 8'h00, 4'h8, 4'hF, 0,
			32'hFFFFFFFF));
		directed.push_back(make_request(FN_UNDEF_LO, 8'h48, 8'h89, 8'hC0, 4'h4, 4'h4,
			32'h1, 32'h1));
		directed.push_back(make_request(FN_UNDEF_HI, 8'hFF, 8'hFF, 8'hFF, 4'hF, 4'hF,
			32'hFFFFFFFF, 32'hFFFFFFFF));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_steady = 1'b0;
		foreach (directed[i])
			send_request(directed[i]);

		n = 0;
		while (sent < directed.size() - 2 + RANDOM_REQUESTS) begin
			if (n % 32 == 0)
				tx_steady = ($urandom_range(0, 3) == 0);
			send_request(random_request());
			n++;
		end
		push <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("requests: %0d encoded, %0d undefined forms; byte beats checked: %0d",
			sent, dropped, beats);
		$display("byte side held off %0d cycles; request stalled by full on %0d cycles",
			HOLD_CYCLES, full_stalls);
		if (fail_count == 0)
			$display("tb_x86_modrm_instruction_encoder: done, clean");
		else
			$display("tb_x86_modrm_instruction_encoder: done, errors");
		$finish;
	end

	initial begin : drain_bytes
		int gap;
		int k;
		wait (arst_n);
		@(posedge clk);
		k = 0;
		forever begin
			if (k % 64 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
			gap = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (gap > 0 || hold_rx) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_rx) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			k++;
		end
	end

	initial begin : hold_off
		wait (arst_n);
		repeat (HOLD_START) @(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin : watchdog
		cycle_count = 0;
		full_stalls = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
			if (push && full)
				full_stalls++;
		end
		$display("%0t timeout after %0d cycles, %0d beats still expected",
			$time, cycle_count, pending);
		$display("tb_x86_modrm_instruction_encoder: done, errors");
		$finish;
	end

endmodule
